[rtl/tli_pkg.sv]
`default_nettype none

package tli_pkg;

    localparam int POS_W     = 24;
    localparam int LEN_W     = 18;
    localparam int ANG_W     = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // request commands
    localparam logic [1:0] CMD_FEED    = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // action table codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_FORWARD = 3'd1;
    localparam logic [2:0] ACT_LEFT    = 3'd2;
    localparam logic [2:0] ACT_RIGHT   = 3'd3;
    localparam logic [2:0] ACT_PUSH    = 3'd4;
    localparam logic [2:0] ACT_POP     = 3'd5;

    // operations passed from front to back
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE    = 3'd0;
    localparam op_t OP_FORWARD = 3'd1;
    localparam op_t OP_LEFT    = 3'd2;
    localparam op_t OP_RIGHT   = 3'd3;
    localparam op_t OP_PUSH    = 3'd4;
    localparam op_t OP_POP     = 3'd5;
    localparam op_t OP_RESTART = 3'd6;

    // result status
    localparam logic [1:0] STATUS_SEGMENT   = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_SCALE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LENGTH = 3'd4;

    localparam logic [LEN_W-1:0] LEN_MAX          = 18'h3FFFF;
    localparam logic [LEN_W-1:0] LEN_RESET        = 18'd13107;  // 0.2 in Q2.16
    localparam logic [LEN_W-1:0] LEN_FACTOR_RESET = 18'd65536;  // 1.0 in Q2.16
    localparam logic [ANG_W-1:0] QUARTER_TURN     = 16'h4000;
    localparam logic [ANG_W-1:0] HALF_TURN        = 16'h8000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] symbol;
        logic [2:0] action_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [POS_W-1:0] seg_start_x;
        logic signed [POS_W-1:0] seg_start_y;
        logic signed [POS_W-1:0] seg_end_x;
        logic signed [POS_W-1:0] seg_end_y;
    } res_item_t;

    typedef struct packed {
        logic [ANG_W-1:0]        angle_step;
        logic [LEN_W-1:0]        len_scale;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic [LEN_W-1:0]        initial_length;
    } cfg_t;

    // quarter-wave sine, 65 points, Q1.16
    function automatic logic [16:0] quarter_sine(input logic [6:0] idx);
        logic [16:0] v;
        case (idx)
            7'd0:  v = 17'd0;
            7'd1:  v = 17'd1608;
            7'd2:  v = 17'd3216;
            7'd3:  v = 17'd4821;
            7'd4:  v = 17'd6424;
            7'd5:  v = 17'd8022;
            7'd6:  v = 17'd9616;
            7'd7:  v = 17'd11204;
            7'd8:  v = 17'd12785;
            7'd9:  v = 17'd14359;
            7'd10: v = 17'd15924;
            7'd11: v = 17'd17479;
            7'd12: v = 17'd19024;
            7'd13: v = 17'd20557;
            7'd14: v = 17'd22078;
            7'd15: v = 17'd23586;
            7'd16: v = 17'd25079;
            7'd17: v = 17'd26558;
            7'd18: v = 17'd28020;
            7'd19: v = 17'd29466;
            7'd20: v = 17'd30893;
            7'd21: v = 17'd32302;
            7'd22: v = 17'd33692;
            7'd23: v = 17'd35061;
            7'd24: v = 17'd36410;
            7'd25: v = 17'd37736;
            7'd26: v = 17'd39040;
            7'd27: v = 17'd40320;
            7'd28: v = 17'd41576;
            7'd29: v = 17'd42806;
            7'd30: v = 17'd44011;
            7'd31: v = 17'd45190;
            7'd32: v = 17'd46341;
            7'd33: v = 17'd47464;
            7'd34: v = 17'd48559;
            7'd35: v = 17'd49624;
            7'd36: v = 17'd50660;
            7'd37: v = 17'd51665;
            7'd38: v = 17'd52639;
            7'd39: v = 17'd53581;
            7'd40: v = 17'd54491;
            7'd41: v = 17'd55368;
            7'd42: v = 17'd56212;
            7'd43: v = 17'd57022;
            7'd44: v = 17'd57797;
            7'd45: v = 17'd58538;
            7'd46: v = 17'd59244;
            7'd47: v = 17'd59913;
            7'd48: v = 17'd60547;
            7'd49: v = 17'd61144;
            7'd50: v = 17'd61705;
            7'd51: v = 17'd62228;
            7'd52: v = 17'd62714;
            7'd53: v = 17'd63162;
            7'd54: v = 17'd63572;
            7'd55: v = 17'd63943;
            7'd56: v = 17'd64277;
            7'd57: v = 17'd64571;
            7'd58: v = 17'd64827;
            7'd59: v = 17'd65043;
            7'd60: v = 17'd65220;
            7'd61: v = 17'd65358;
            7'd62: v = 17'd65457;
            7'd63: v = 17'd65516;
            7'd64: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/tli_ram.sv]
`default_nettype none

module tli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/tli_fifo.sv]
`default_nettype none

module tli_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST     = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tli_front.sv]
`default_nettype none

module tli_front #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tli_pkg::in_item_t item,
    output logic              op_write,
    output tli_pkg::op_t      op_data,
    input  logic              op_full
);

    import tli_pkg::*;

    localparam int SAW = $clog2(SYMBOL_COUNT);
    localparam logic [8:0] SYM_LIMIT = 9'(SYMBOL_COUNT);

    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic                    s1_valid_reg;
    logic [1:0]              s1_cmd_reg;
    logic                    s1_hit_reg;
    logic [2:0]              tbl_rdata;
    logic [SAW-1:0]          idx;
    logic                    in_range;
    logic                    accept;
    logic                    tbl_we;
    logic                    tbl_re;
    logic                    entry_valid;
    op_t                     s1_op;

    assign idx         = item.symbol[SAW-1:0];
    assign in_range    = ({1'b0, item.symbol} < SYM_LIMIT);
    assign entry_valid = in_range ? valid_reg[idx] : 1'b0;
    assign accept      = push && !full;
    assign tbl_we      = accept && (item.cmd == CMD_LOAD) && in_range;
    assign tbl_re      = accept && (item.cmd == CMD_FEED) && in_range;

    tli_ram #(
        .WIDTH(3),
        .DEPTH(SYMBOL_COUNT)
    ) u_action_ram (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(idx),
        .wdata(item.action_code),
        .re   (tbl_re),
        .raddr(idx),
        .rdata(tbl_rdata)
    );

    // decode the looked-up action into a back-end operation
    always_comb
    begin
        s1_op = OP_NONE;
        case (s1_cmd_reg)
            CMD_FEED:
            begin
                if (s1_hit_reg)
                begin
                    case (tbl_rdata)
                        ACT_FORWARD: s1_op = OP_FORWARD;
                        ACT_LEFT:    s1_op = OP_LEFT;
                        ACT_RIGHT:   s1_op = OP_RIGHT;
                        ACT_PUSH:    s1_op = OP_PUSH;
                        ACT_POP:     s1_op = OP_POP;
                        default:     s1_op = OP_NONE;
                    endcase
                end
            end
            CMD_RESTART: s1_op = OP_RESTART;
            default:     s1_op = OP_NONE;
        endcase
    end

    // hold the classified request while the queue is full; drop no-ops
    assign full     = s1_valid_reg && (s1_op != OP_NONE) && op_full;
    assign op_write = s1_valid_reg && (s1_op != OP_NONE) && !op_full;
    assign op_data  = s1_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || full;
            if (tbl_we)
            begin
                valid_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= item.cmd;
            s1_hit_reg <= entry_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/tli_back.sv]
`default_nettype none

module tli_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tli_pkg::cfg_t      cfg,
    input  tli_pkg::op_t       op_data,
    input  logic               op_empty,
    output logic               op_read,
    input  logic               res_full,
    output logic               res_write,
    output tli_pkg::res_item_t res_data
);

    import tli_pkg::*;

    localparam int SAW     = $clog2(STACK_DEPTH);
    localparam int SPW     = $clog2(STACK_DEPTH + 1);
    localparam int FRAME_W = 2 * POS_W + ANG_W + LEN_W;
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MUL   = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;
    localparam logic [1:0] S_POPLD = 2'd3;

    localparam logic signed [POS_W+1:0] POS_HI = 26'sd8388607;
    localparam logic signed [POS_W+1:0] POS_LO = -26'sd8388608;

    logic [1:0]              state_reg, state_next;
    logic signed [POS_W-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0] pos_y_reg, pos_y_next;
    logic [ANG_W-1:0]        heading_reg, heading_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [SPW-1:0]          sp_reg, sp_next;
    logic [SPW-1:0]          sp_dec;

    logic [16:0]             mag_x_reg, mag_y_reg;
    logic                    neg_x_reg, neg_y_reg;
    logic [34:0]             prod_x_reg, prod_y_reg;
    logic [35:0]             prod_l_reg;

    logic [17:0]             trig_x, trig_y;
    logic signed [POS_W-1:0] end_x, end_y;
    logic [36:0]             sum_l;
    logic [20:0]             len_round;
    logic [LEN_W-1:0]        len_scaled;

    logic                    st_we, st_re;
    logic [FRAME_W-1:0]      st_rdata;

    function automatic logic [16:0] quarter_mag(input logic [14:0] u);
        logic [16:0] a;
        logic [16:0] b;
        logic [19:0] t;
        logic [16:0] m;
        a = quarter_sine({1'b0, u[13:8]});
        b = quarter_sine({1'b0, u[13:8]} + 7'd1);
        t = 20'(b - a) * 20'(u[7:0]) + 20'd128;
        m = a + 17'(t[19:8]);
        return u[14] ? 17'd65536 : m;
    endfunction

    // sign and magnitude of sin(p)
    function automatic logic [17:0] sine_parts(input logic [15:0] p);
        logic [14:0] u;
        u = p[14] ? (15'h4000 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
        return {p[15], quarter_mag(u)};
    endfunction

    // round half away from zero, add, saturate to 24 bits
    function automatic logic signed [POS_W-1:0] step_pos(
        input logic signed [POS_W-1:0] pos,
        input logic                    neg,
        input logic [34:0]             prod
    );
        logic [34:0]             sum;
        logic signed [POS_W+1:0] base;
        logic signed [POS_W+1:0] step;
        logic signed [POS_W+1:0] n;
        logic signed [POS_W-1:0] r;
        sum  = prod + 35'd32768;
        base = (POS_W + 2)'(pos);
        step = $signed((POS_W + 2)'(sum[34:16]));
        n    = neg ? (base - step) : (base + step);
        r    = $signed(n[POS_W-1:0]);
        if (n > POS_HI)
        begin
            r = POS_HI[POS_W-1:0];
        end
        else if (n < POS_LO)
        begin
            r = POS_LO[POS_W-1:0];
        end
        return r;
    endfunction

    // direction of travel is heading plus a quarter turn; x uses cosine
    assign trig_x = sine_parts(heading_reg + HALF_TURN);
    assign trig_y = sine_parts(heading_reg + QUARTER_TURN);

    assign end_x      = step_pos(pos_x_reg, neg_x_reg, prod_x_reg);
    assign end_y      = step_pos(pos_y_reg, neg_y_reg, prod_y_reg);
    assign sum_l      = 37'(prod_l_reg) + 37'd32768;
    assign len_round  = sum_l[36:16];
    assign len_scaled = (len_round > 21'(LEN_MAX)) ? LEN_MAX : len_round[LEN_W-1:0];
    assign sp_dec     = sp_reg - 1'b1;

    tli_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .clk  (clk),
        .we   (st_we),
        .waddr(sp_reg[SAW-1:0]),
        .wdata({pos_x_reg, pos_y_reg, heading_reg, len_reg}),
        .re   (st_re),
        .raddr(sp_dec[SAW-1:0]),
        .rdata(st_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        len_next     = len_reg;
        sp_next      = sp_reg;
        op_read      = 1'b0;
        res_write    = 1'b0;
        res_data     = '0;
        st_we        = 1'b0;
        st_re        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // start only with room for a possible result
                if (!op_empty && !res_full)
                begin
                    op_read = 1'b1;
                    case (op_data)
                        OP_FORWARD: state_next = S_MUL;
                        OP_LEFT:    heading_next = heading_reg + cfg.angle_step;
                        OP_RIGHT:   heading_next = heading_reg - cfg.angle_step;
                        OP_PUSH:
                        begin
                            if (sp_reg == SP_FULL)
                            begin
                                res_write       = 1'b1;
                                res_data.status = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                st_we   = 1'b1;
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (sp_reg == '0)
                            begin
                                res_write       = 1'b1;
                                res_data.status = STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                sp_next    = sp_dec;
                                state_next = S_POPLD;
                            end
                        end
                        OP_RESTART:
                        begin
                            pos_x_next   = cfg.start_x;
                            pos_y_next   = cfg.start_y;
                            heading_next = '0;
                            len_next     = cfg.initial_length;
                            sp_next      = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                res_write            = 1'b1;
                res_data.status      = STATUS_SEGMENT;
                res_data.seg_start_x = pos_x_reg;
                res_data.seg_start_y = pos_y_reg;
                res_data.seg_end_x   = end_x;
                res_data.seg_end_y   = end_y;
                pos_x_next           = end_x;
                pos_y_next           = end_y;
                len_next             = len_scaled;
                state_next           = S_IDLE;
            end
            S_POPLD:
            begin
                {pos_x_next, pos_y_next, heading_next, len_next} = st_rdata;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
            len_reg     <= LEN_RESET;
            sp_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
            len_reg     <= len_next;
            sp_reg      <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            {neg_x_reg, mag_x_reg} <= trig_x;
            {neg_y_reg, mag_y_reg} <= trig_y;
        end
        if (state_reg == S_MUL)
        begin
            prod_x_reg <= 35'(len_reg) * 35'(mag_x_reg);
            prod_y_reg <= 35'(len_reg) * 35'(mag_y_reg);
            prod_l_reg <= 36'(len_reg) * 36'(cfg.len_scale);
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond stack depth");

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_write |-> !res_full)
        else $error("result written into a full output queue");

    a_busy_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !op_read)
        else $error("operation taken while busy");

    a_popld_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POPLD) |-> ($past(state_reg) == S_IDLE))
        else $error("stack load without a pop issue");

endmodule

`default_nettype wire

[rtl/turtle_line_interpreter_core.sv]
`default_nettype none

// Turtle interpreter for L-system symbol streams. Requests enter through a
// queue-style port (push/full) and carry a command: feed a symbol, load one
// action table entry, or restart the turtle at the configured start point.
// Each fed symbol is looked up in the action table (all entries read as "no
// action" after reset) and carried out: forward emits one line segment with
// start and end in signed Q8.16 and scales the segment length, left and right
// turn by angle_step, push and pop save and restore the turtle state on a
// stack of STACK_DEPTH frames. A push on a full stack or a pop on an empty one
// changes nothing and returns a flagged result with zero coordinates.
// Results leave through a second queue-style port (empty/pop). Rate: the
// front takes one request per cycle while its operation queue has room;
// loads, unmapped symbols and no-op actions end there and never cost a back
// cycle. The back sequencer runs a forward as sine/cosine lookup, length
// multiply, add and saturate, a pop as stack RAM read then frame load, and
// a turn, push or restart in idle. The user must write configuration only
// while idle; the block does not enforce it. The stack RAM needs no clearing
// pass; the action table has one valid bit per entry, cleared at reset.

module turtle_line_interpreter_core #(
    parameter int STACK_DEPTH  = 64,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request side
    input  logic                              push,
    output logic                              full,
    input  tli_pkg::in_item_t                 item,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output tli_pkg::res_item_t                result,
    // configuration
    input  logic                              cfg_write,
    input  logic [tli_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tli_pkg::CFG_W-1:0]         cfg_data
);

    import tli_pkg::*;

    localparam int OP_QUEUE_DEPTH  = 4;
    localparam int RES_QUEUE_DEPTH = 2;
    localparam int RES_W           = $bits(res_item_t);

    cfg_t             cfg_reg;
    logic             op_write;
    op_t              op_wdata;
    logic             op_full;
    logic             op_read;
    logic [2:0]       op_rdata;
    logic             op_empty;
    logic             res_write;
    res_item_t        res_wdata;
    logic             res_full;
    logic [RES_W-1:0] res_rdata;

    // Configuration registers: take the low bits of the write data; ignore
    // indexes beyond the last register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_step     <= '0;
            cfg_reg.len_scale      <= LEN_FACTOR_RESET;
            cfg_reg.start_x        <= '0;
            cfg_reg.start_y        <= '0;
            cfg_reg.initial_length <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ANGLE_STEP:     cfg_reg.angle_step     <= cfg_data[ANG_W-1:0];
                CFG_LEN_SCALE:      cfg_reg.len_scale      <= cfg_data[LEN_W-1:0];
                CFG_START_X:        cfg_reg.start_x        <= $signed(cfg_data[POS_W-1:0]);
                CFG_START_Y:        cfg_reg.start_y        <= $signed(cfg_data[POS_W-1:0]);
                CFG_INITIAL_LENGTH: cfg_reg.initial_length <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front: accept requests, update or read the action table, classify.
    tli_front #(
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .op_write(op_write),
        .op_data (op_wdata),
        .op_full (op_full)
    );

    // Operation queue: decouple table lookup from turtle execution.
    tli_fifo #(
        .WIDTH(3),
        .DEPTH(OP_QUEUE_DEPTH)
    ) u_op_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (op_write),
        .wr_data(op_wdata),
        .full   (op_full),
        .rd_en  (op_read),
        .rd_data(op_rdata),
        .empty  (op_empty)
    );

    // Back: turtle state, stack and segment arithmetic.
    tli_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op_data  (op_rdata),
        .op_empty (op_empty),
        .op_read  (op_read),
        .res_full (res_full),
        .res_write(res_write),
        .res_data (res_wdata)
    );

    // Result queue: hold finished results until the consumer pops them.
    tli_fifo #(
        .WIDTH(RES_W),
        .DEPTH(RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_write),
        .wr_data(res_wdata),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(res_rdata),
        .empty  (empty)
    );

    assign result = res_rdata;

endmodule

`default_nettype wire
